@@ src/ipk_pkg.sv @@
// Shared types, constants and the speed-to-unit table for the iambic paddle keyer.
`timescale 1ns / 1ps
package ipk_pkg;

	typedef enum logic [1:0] {
		EL_NONE = 2'd0,
		EL_DIT  = 2'd1,
		EL_DAH  = 2'd2
	} elem_t;

	typedef enum logic [1:0] {
		MODE_PADDLE     = 2'd0,
		MODE_REVERSED   = 2'd1,
		MODE_STRAIGHT   = 2'd2,
		MODE_STRAIGHT_2 = 2'd3
	} mode_t;

	localparam int UNIT_W  = 8;
	localparam int COUNT_W = 10;
	localparam int WPM_W   = 6;

	localparam logic CFG_KEY_MODE = 1'b0;
	localparam logic CFG_WPM      = 1'b1;

	localparam logic [UNIT_W-1:0] UNIT_RESET = 8'd60;

	// Unit length in ms (1200 / wpm), speed clamped to 5..60.
	function automatic logic [UNIT_W-1:0] unit_for_wpm(input logic [WPM_W-1:0] wpm);
		logic [UNIT_W-1:0] u;
		begin
			unique case (wpm)
				6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5: u = 8'd240;
				6'd6:  u = 8'd200;
				6'd7:  u = 8'd171;
				6'd8:  u = 8'd150;
				6'd9:  u = 8'd133;
				6'd10: u = 8'd120;
				6'd11: u = 8'd109;
				6'd12: u = 8'd100;
				6'd13: u = 8'd92;
				6'd14: u = 8'd85;
				6'd15: u = 8'd80;
				6'd16: u = 8'd75;
				6'd17: u = 8'd70;
				6'd18: u = 8'd66;
				6'd19: u = 8'd63;
				6'd20: u = 8'd60;
				6'd21: u = 8'd57;
				6'd22: u = 8'd54;
				6'd23: u = 8'd52;
				6'd24: u = 8'd50;
				6'd25: u = 8'd48;
				6'd26: u = 8'd46;
				6'd27: u = 8'd44;
				6'd28: u = 8'd42;
				6'd29: u = 8'd41;
				6'd30: u = 8'd40;
				6'd31: u = 8'd38;
				6'd32: u = 8'd37;
				6'd33: u = 8'd36;
				6'd34: u = 8'd35;
				6'd35: u = 8'd34;
				6'd36: u = 8'd33;
				6'd37: u = 8'd32;
				6'd38: u = 8'd31;
				6'd39, 6'd40: u = 8'd30;
				6'd41: u = 8'd29;
				6'd42: u = 8'd28;
				6'd43, 6'd44: u = 8'd27;
				6'd45, 6'd46: u = 8'd26;
				6'd47, 6'd48: u = 8'd25;
				6'd49, 6'd50: u = 8'd24;
				6'd51, 6'd52: u = 8'd23;
				6'd53, 6'd54: u = 8'd22;
				6'd55, 6'd56, 6'd57: u = 8'd21;
				default: u = 8'd20;
			endcase
			return u;
		end
	endfunction

endpackage

@@ src/ipk_tick_if.sv @@
// Request channel carrying one contact sample per tick.
`timescale 1ns / 1ps
interface ipk_tick_if;
	logic valid;
	logic ready;
	logic tip_down;
	logic ring_down;

	modport source (output valid, output tip_down, output ring_down, input ready);
	modport sink (input valid, input tip_down, input ring_down, output ready);
endinterface

@@ src/ipk_key_if.sv @@
// Request channel carrying the key level and started element per tick.
`timescale 1ns / 1ps
interface ipk_key_if;
	logic       valid;
	logic       ready;
	logic       key_level;
	logic [1:0] element_started;

	modport source (output valid, output key_level, output element_started, input ready);
	modport sink (input valid, input key_level, input element_started, output ready);
endinterface

@@ src/iambic_paddle_keyer.sv @@
// Iambic paddle keyer (mode B) with straight-key modes: top level.
// Usage:
//   ticks   : one request per 1 ms tick with the tip and ring contact levels.
//   results : one request per tick with key_level and element_started
//             (0 none, 1 dit, 2 dah).
//   cfg_*   : write port; index 0 key_mode, index 1 words_per_minute.
//             Write only when no tick is in flight.
// Pipeline: one input register, then the keyer update and the result register.
// One tick is taken every cycle while the result register
// is empty or being drained.
// Dit = 1 unit, dah = 3 units, each plus a 1-unit gap; unit = 1200/wpm ticks,
// looked up from a table when the speed is written.
// Reset: paddle mode, 20 wpm (unit 60), keyer idle, both stages empty.
// When results.ready is low with a valid result, the result is held and
// ticks.ready drops; the whole pipe stalls and only cfg writes move keyer state.
`timescale 1ns / 1ps
module iambic_paddle_keyer (
	input  logic                         clk,
	input  logic                         arst_n,
	ipk_tick_if.sink                     ticks,
	ipk_key_if.source                    results,
	input  logic                         cfg_wr_en,
	input  logic                         cfg_index,
	input  logic [ipk_pkg::WPM_W-1:0]    cfg_data
);

	localparam int CW = ipk_pkg::COUNT_W;

	logic advance;
	logic valid_s1, tip_s1, ring_s1;
	logic valid_s2, key_level_s2;
	ipk_pkg::elem_t element_s2;

	ipk_pkg::mode_t             mode_q;
	logic [ipk_pkg::UNIT_W-1:0] unit_q;
	logic                       waiting_q;
	logic [CW-1:0]              tone_q, ready_q;
	ipk_pkg::elem_t             prev_q;
	logic                       ditm_q, dahm_q, squeeze_q, extra_q;

	logic                       waiting_d;
	logic [CW-1:0]              tone_d, ready_d;
	ipk_pkg::elem_t             prev_d, next_el;
	logic                       ditm_d, dahm_d, squeeze_d, extra_d;
	logic                       level_d;

	assign advance        = !valid_s2 || results.ready;
	assign ticks.ready    = advance;
	assign results.valid  = valid_s2;
	assign results.key_level       = key_level_s2;
	assign results.element_started = element_s2;

	always_comb begin
		logic dit, dah, both, gap_done;
		logic [CW-1:0] t1, r1, unit_w, el_tone;
		logic sq1, dm1, hm1, ex1;
		ipk_pkg::elem_t other;
		dit = (mode_q == ipk_pkg::MODE_REVERSED) ? ring_s1 : tip_s1;
		dah = (mode_q == ipk_pkg::MODE_REVERSED) ? tip_s1 : ring_s1;
		both = dit && dah;
		other = (prev_q == ipk_pkg::EL_DIT) ? ipk_pkg::EL_DAH : ipk_pkg::EL_DIT;
		unit_w = CW'(unit_q);

		// Count down and collect paddle memories while an element runs.
		t1  = tone_q;
		r1  = ready_q;
		sq1 = squeeze_q;
		dm1 = ditm_q;
		hm1 = dahm_q;
		ex1 = extra_q;
		if (waiting_q) begin
			if (tone_q != '0) t1 = tone_q - CW'(1);
			if (ready_q != '0) r1 = ready_q - CW'(1);
			sq1 = squeeze_q || both;
			dm1 = ditm_q || (dit && prev_q == ipk_pkg::EL_DAH);
			hm1 = dahm_q || (dah && prev_q == ipk_pkg::EL_DIT);
			ex1 = extra_q || (!dit && !dah && sq1 && t1 != '0);
		end
		gap_done = !waiting_q || r1 == '0;

		waiting_d = waiting_q;
		tone_d    = t1;
		ready_d   = r1;
		prev_d    = prev_q;
		ditm_d    = dm1;
		dahm_d    = hm1;
		squeeze_d = sq1;
		extra_d   = ex1;
		next_el   = ipk_pkg::EL_NONE;
		el_tone   = '0;

		if (gap_done) begin
			priority if (ex1) begin
				extra_d   = 1'b0;
				squeeze_d = 1'b0;
				next_el   = other;
			end else if (both) begin
				squeeze_d = 1'b1;
				next_el   = other;
			end else if (dm1) begin
				next_el = ipk_pkg::EL_DIT;
			end else if (hm1) begin
				next_el = ipk_pkg::EL_DAH;
			end else if (dit) begin
				next_el = ipk_pkg::EL_DIT;
			end else if (dah) begin
				next_el = ipk_pkg::EL_DAH;
			end else begin
				next_el = ipk_pkg::EL_NONE;
			end

			el_tone = (next_el == ipk_pkg::EL_DIT) ? unit_w : (unit_w << 1) + unit_w;
			if (next_el != ipk_pkg::EL_NONE) begin
				if (next_el == ipk_pkg::EL_DIT) ditm_d = 1'b0;
				else dahm_d = 1'b0;
				prev_d    = next_el;
				waiting_d = 1'b1;
				tone_d    = el_tone;
				ready_d   = el_tone + unit_w;
			end else begin
				waiting_d = 1'b0;
				tone_d    = '0;
				ready_d   = '0;
				prev_d    = ipk_pkg::EL_NONE;
				ditm_d    = 1'b0;
				dahm_d    = 1'b0;
				squeeze_d = 1'b0;
				extra_d   = 1'b0;
			end
		end
		level_d = waiting_d && tone_d != '0;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= ticks.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tip_s1  <= ticks.tip_down;
			ring_s1 <= ticks.ring_down;
		end
	end

	// Keyer state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			mode_q    <= ipk_pkg::MODE_PADDLE;
			unit_q    <= ipk_pkg::UNIT_RESET;
			waiting_q <= 1'b0;
			tone_q    <= '0;
			ready_q   <= '0;
			prev_q    <= ipk_pkg::EL_NONE;
			ditm_q    <= 1'b0;
			dahm_q    <= 1'b0;
			squeeze_q <= 1'b0;
			extra_q   <= 1'b0;
		end else begin
			if (advance) valid_s2 <= valid_s1;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					ipk_pkg::CFG_KEY_MODE: begin
						mode_q <= ipk_pkg::mode_t'(cfg_data[1:0]);
						if (cfg_data[1:0] != mode_q) begin
							waiting_q <= 1'b0;
							tone_q    <= '0;
							ready_q   <= '0;
							prev_q    <= ipk_pkg::EL_NONE;
							ditm_q    <= 1'b0;
							dahm_q    <= 1'b0;
							squeeze_q <= 1'b0;
							extra_q   <= 1'b0;
						end
					end
					ipk_pkg::CFG_WPM: begin
						unit_q <= ipk_pkg::unit_for_wpm(cfg_data);
					end
				endcase
			end else if (advance && valid_s1) begin
				if (mode_q == ipk_pkg::MODE_PADDLE || mode_q == ipk_pkg::MODE_REVERSED) begin
					waiting_q <= waiting_d;
					tone_q    <= tone_d;
					ready_q   <= ready_d;
					prev_q    <= prev_d;
					ditm_q    <= ditm_d;
					dahm_q    <= dahm_d;
					squeeze_q <= squeeze_d;
					extra_q   <= extra_d;
				end else begin
					waiting_q <= 1'b0;
					tone_q    <= '0;
					ready_q   <= '0;
					prev_q    <= ipk_pkg::EL_NONE;
					ditm_q    <= 1'b0;
					dahm_q    <= 1'b0;
					squeeze_q <= 1'b0;
					extra_q   <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			if (mode_q == ipk_pkg::MODE_PADDLE || mode_q == ipk_pkg::MODE_REVERSED) begin
				key_level_s2 <= level_d;
				element_s2   <= next_el;
			end else begin
				key_level_s2 <= (mode_q == ipk_pkg::MODE_STRAIGHT) ? tip_s1 : (tip_s1 || ring_s1);
				element_s2   <= ipk_pkg::EL_NONE;
			end
		end
	end

`ifndef SYNTHESIS
	// An idle keyer has no timers running.
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!waiting_q |-> (tone_q == '0 && ready_q == '0))
		else $error("keyer idle with timers running");

	// The tone never outlasts the element slot.
	a_tone_in_slot: assert property (@(posedge clk) disable iff (!arst_n)
		tone_q <= ready_q)
		else $error("tone longer than element slot");

	// An element starts with the key on.
	a_start_keyed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && element_s2 != ipk_pkg::EL_NONE) |-> key_level_s2)
		else $error("element started with key off");

	// A stalled result does not move the keyer.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !results.ready && !cfg_wr_en) |=> $stable(tone_q) && $stable(ready_q))
		else $error("keyer state moved during stall");
`endif

endmodule

@@ test/tb_iambic_paddle_keyer.sv @@
// Testbench for the iambic paddle keyer: tick stimulus, keyer prediction and result checks.
`timescale 1ns / 1ps
module tb_iambic_paddle_keyer;

	typedef struct packed {
		logic tip;
		logic ring;
	} contact_t;

	typedef struct packed {
		logic           level;
		ipk_pkg::elem_t started;
	} key_result_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_wr_en;
	logic                      cfg_index;
	logic [ipk_pkg::WPM_W-1:0] cfg_data;

	ipk_tick_if tick_bus();
	ipk_key_if  key_bus();

	iambic_paddle_keyer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.ticks    (tick_bus),
		.results  (key_bus),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	contact_t    contact_queue[$];
	key_result_t key_expect[$];
	int          mismatch_count = 0;
	int          sender_idle_pct = 0;
	int          receiver_idle_pct = 0;
	logic        tick_taken = 1'b0;

	// Keyer model state
	ipk_pkg::mode_t              kb_mode;
	logic [ipk_pkg::UNIT_W-1:0]  kb_unit;
	logic                        kb_in_element;
	logic [ipk_pkg::COUNT_W-1:0] kb_tone_left;
	logic [ipk_pkg::COUNT_W-1:0] kb_gap_left;
	ipk_pkg::elem_t              kb_last;
	logic                        kb_dit_mem;
	logic                        kb_dah_mem;
	logic                        kb_squeeze;
	logic                        kb_extra;

	function automatic void clear_keyer();
		kb_in_element = 1'b0;
		kb_tone_left  = '0;
		kb_gap_left   = '0;
		kb_last       = ipk_pkg::EL_NONE;
		kb_dit_mem    = 1'b0;
		kb_dah_mem    = 1'b0;
		kb_squeeze    = 1'b0;
		kb_extra      = 1'b0;
	endfunction

	function automatic ipk_pkg::elem_t opposite(ipk_pkg::elem_t e);
		return (e == ipk_pkg::EL_DIT) ? ipk_pkg::EL_DAH : ipk_pkg::EL_DIT;
	endfunction

	function automatic void start_element(ipk_pkg::elem_t e);
		logic [ipk_pkg::COUNT_W-1:0] tone;
		tone = (e == ipk_pkg::EL_DIT) ? {2'b00, kb_unit} : 10'd3 * {2'b00, kb_unit};
		if (e == ipk_pkg::EL_DIT)
			kb_dit_mem = 1'b0;
		else
			kb_dah_mem = 1'b0;
		kb_last       = e;
		kb_in_element = 1'b1;
		kb_tone_left  = tone;
		kb_gap_left   = tone + {2'b00, kb_unit};
	endfunction

	function automatic void keyer_predict(input logic tip, input logic ring,
			output logic lvl, output ipk_pkg::elem_t started);
		logic           dit;
		logic           dah;
		logic           both;
		logic           busy;
		ipk_pkg::elem_t nxt;
		started = ipk_pkg::EL_NONE;
		busy = 1'b0;
		if (kb_mode == ipk_pkg::MODE_PADDLE || kb_mode == ipk_pkg::MODE_REVERSED) begin
			dit  = (kb_mode == ipk_pkg::MODE_REVERSED) ? ring : tip;
			dah  = (kb_mode == ipk_pkg::MODE_REVERSED) ? tip : ring;
			both = dit && dah;
			if (kb_in_element) begin
				if (kb_tone_left != 0)
					kb_tone_left = kb_tone_left - 1'b1;
				if (kb_gap_left != 0)
					kb_gap_left = kb_gap_left - 1'b1;
				if (both)
					kb_squeeze = 1'b1;
				if (dit && kb_last == ipk_pkg::EL_DAH)
					kb_dit_mem = 1'b1;
				if (dah && kb_last == ipk_pkg::EL_DIT)
					kb_dah_mem = 1'b1;
				// squeeze let go while the tone still sounds earns one more element
				if (!dit && !dah && kb_squeeze && !kb_extra && kb_tone_left != 0)
					kb_extra = 1'b1;
				if (kb_gap_left != 0)
					busy = 1'b1;
				else
					kb_in_element = 1'b0;
			end
			if (!busy) begin
				if (kb_extra) begin
					kb_extra   = 1'b0;
					kb_squeeze = 1'b0;
					nxt = opposite(kb_last);
				end else if (both) begin
					kb_squeeze = 1'b1;
					nxt = opposite(kb_last);
				end else if (kb_dit_mem)
					nxt = ipk_pkg::EL_DIT;
				else if (kb_dah_mem)
					nxt = ipk_pkg::EL_DAH;
				else if (dit)
					nxt = ipk_pkg::EL_DIT;
				else if (dah)
					nxt = ipk_pkg::EL_DAH;
				else
					nxt = ipk_pkg::EL_NONE;
				if (nxt != ipk_pkg::EL_NONE)
					start_element(nxt);
				else
					clear_keyer();
				started = nxt;
			end
			lvl = kb_in_element && kb_tone_left != 0;
		end else begin
			clear_keyer();
			lvl = (kb_mode == ipk_pkg::MODE_STRAIGHT) ? tip : (tip || ring);
		end
	endfunction

	function automatic void apply_reg(input logic idx, input logic [ipk_pkg::WPM_W-1:0] data);
		int w;
		if (idx == ipk_pkg::CFG_KEY_MODE) begin
			if (ipk_pkg::mode_t'(data[1:0]) != kb_mode)
				clear_keyer();
			kb_mode = ipk_pkg::mode_t'(data[1:0]);
		end else begin
			w = int'(data);
			if (w < 5)
				w = 5;
			if (w > 60)
				w = 60;
			kb_unit = ipk_pkg::UNIT_W'(1200 / w);
		end
	endfunction

	task automatic write_reg(input logic idx, input logic [ipk_pkg::WPM_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		apply_reg(idx, data);
	endtask

	// upper bits of a mode write are don't-care, so they get random values
	task automatic write_mode(input ipk_pkg::mode_t m);
		logic [3:0] hi;
		hi = 4'($urandom_range(0, 15));
		write_reg(ipk_pkg::CFG_KEY_MODE, {hi, m});
	endtask

	task automatic wait_idle();
		while (contact_queue.size() != 0 || tick_bus.valid || key_expect.size() != 0)
			@(posedge clk);
	endtask

	task automatic queue_hold(input logic tip, input logic ring, input int n);
		contact_t c;
		c.tip  = tip;
		c.ring = ring;
		repeat (n) contact_queue.push_back(c);
	endtask

	// Paddle modes get contact patterns held for element-scale stretches,
	// with some short noisy bursts mixed in.
	task automatic random_contacts(input int n_ticks);
		int         made;
		int         len;
		logic [1:0] combo;
		made = 0;
		while (made < n_ticks) begin
			combo = 2'($urandom_range(0, 3));
			if (kb_mode == ipk_pkg::MODE_PADDLE || kb_mode == ipk_pkg::MODE_REVERSED) begin
				if ($urandom_range(0, 99) < 80)
					len = $urandom_range(1, 3 * kb_unit);
				else
					len = $urandom_range(1, 3);
			end else
				len = $urandom_range(1, 6);
			if (len > n_ticks - made)
				len = n_ticks - made;
			queue_hold(combo[1], combo[0], len);
			made += len;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		contact_t c;
		if (!arst_n)
			tick_bus.valid <= 1'b0;
		else if (!tick_bus.valid || tick_taken) begin
			if (contact_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				c = contact_queue.pop_front();
				tick_bus.valid     <= 1'b1;
				tick_bus.tip_down  <= c.tip;
				tick_bus.ring_down <= c.ring;
			end else
				tick_bus.valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		key_bus.ready <= arst_n && ($urandom_range(0, 99) >= receiver_idle_pct);
	end

	always @(posedge clk) begin
		key_result_t    want;
		logic           lvl;
		ipk_pkg::elem_t st;
		tick_taken = arst_n && tick_bus.valid && tick_bus.ready;
		if (tick_taken) begin
			keyer_predict(tick_bus.tip_down, tick_bus.ring_down, lvl, st);
			want.level   = lvl;
			want.started = st;
			key_expect.push_back(want);
		end
		if (arst_n && key_bus.valid && key_bus.ready) begin
			if (key_expect.size() == 0) begin
				$display("%0t: unexpected result key_level=%0b element_started=%0d",
					$time, key_bus.key_level, key_bus.element_started);
				mismatch_count++;
			end else begin
				want = key_expect.pop_front();
				if (key_bus.key_level !== want.level) begin
					$display("%0t: key_level expected %0b actual %0b",
						$time, want.level, key_bus.key_level);
					mismatch_count++;
				end
				if (key_bus.element_started !== want.started) begin
					$display("%0t: element_started expected %0d actual %0d",
						$time, want.started, key_bus.element_started);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tb_iambic_paddle_keyer: errors");
		$finish;
	end

	initial begin
		ipk_pkg::mode_t m;
		logic [5:0]     wpm;
		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_index          = ipk_pkg::CFG_KEY_MODE;
		cfg_data           = '0;
		tick_bus.valid     = 1'b0;
		tick_bus.tip_down  = 1'b0;
		tick_bus.ring_down = 1'b0;
		key_bus.ready      = 1'b0;
		kb_mode = ipk_pkg::MODE_PADDLE;
		kb_unit = ipk_pkg::UNIT_RESET;
		clear_keyer();
		sender_idle_pct   = 6;
		receiver_idle_pct = 65;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: idle paddles, then a dit at 20 wpm
		queue_hold(1'b0, 1'b0, 1);
		queue_hold(1'b1, 1'b0, 1);
		wait_idle();
		write_mode(ipk_pkg::MODE_STRAIGHT);
		queue_hold(1'b0, 1'b0, 1);
		queue_hold(1'b1, 1'b0, 1);
		queue_hold(1'b0, 1'b1, 1);
		queue_hold(1'b1, 1'b1, 1);
		wait_idle();
		write_mode(ipk_pkg::MODE_STRAIGHT_2);
		queue_hold(1'b0, 1'b0, 1);
		queue_hold(1'b1, 1'b0, 1);
		queue_hold(1'b0, 1'b1, 1);
		queue_hold(1'b1, 1'b1, 1);
		wait_idle();
		// squeeze from idle gives a dit; releasing it during the tone arms an extra dah
		write_mode(ipk_pkg::MODE_PADDLE);
		queue_hold(1'b1, 1'b1, 1);
		queue_hold(1'b0, 1'b0, 2);
		wait_idle();
		// speed and same-mode writes in the middle of an element
		write_reg(ipk_pkg::CFG_WPM, 6'd60);
		write_mode(ipk_pkg::MODE_PADDLE);
		queue_hold(1'b0, 1'b1, 3);
		wait_idle();
		write_reg(ipk_pkg::CFG_WPM, 6'd0);
		write_mode(ipk_pkg::MODE_REVERSED);
		queue_hold(1'b0, 1'b1, 1);
		queue_hold(1'b1, 1'b0, 2);
		wait_idle();
		write_reg(ipk_pkg::CFG_WPM, 6'd63);
		write_mode(ipk_pkg::MODE_PADDLE);
		queue_hold(1'b0, 1'b1, 1);
		queue_hold(1'b0, 1'b0, 1);

		for (int p = 0; p < 6; p++) begin
			wait_idle();
			sender_idle_pct   = (p < 2) ? 6 : (p < 4) ? 65 : 0;
			receiver_idle_pct = (p < 2) ? 65 : (p < 4) ? 6 : 0;
			wpm = (p == 2) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(45, 63));
			write_reg(ipk_pkg::CFG_WPM, wpm);
			if (p == 4)
				m = ipk_pkg::mode_t'($urandom_range(2, 3));
			else if ($urandom_range(0, 3) == 0)
				m = kb_mode;
			else
				m = ipk_pkg::mode_t'($urandom_range(0, 1));
			write_mode(m);
			random_contacts(200);
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_iambic_paddle_keyer: clean");
		else
			$display("tb_iambic_paddle_keyer: errors");
		$finish;
	end

endmodule

@@ filelist.f @@
src/ipk_pkg.sv
src/ipk_tick_if.sv
src/ipk_key_if.sv
src/iambic_paddle_keyer.sv
test/tb_iambic_paddle_keyer.sv
